>>> design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Plain condition that must hold on every rising edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	`ASSERT_CLK(label, (1'b1) |-> (cond), msg)

`endif

>>> design/mpqpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpqpwm_pkg: motor power queue to PWM duty, shared types and constants
// Beat structs of both channels, status codes, register indexes and resets.
// ----------------------------------------------------------------------------
package mpqpwm_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;

	localparam int DUTY_W  = 16;
	localparam int POWER_W = 32;

	// PWM period and loop latency give the reset duty limits
	localparam int PERIOD_TICKS = 50000;
	localparam int PWM_LATENCY  = 4;

	localparam logic [DUTY_W-1:0] MIN_DUTY_RST = DUTY_W'(PWM_LATENCY);
	localparam logic [DUTY_W-1:0] MAX_DUTY_RST = DUTY_W'(PERIOD_TICKS - PWM_LATENCY);

	// command codes
	localparam logic CMD_PUSH    = 1'b0;
	localparam logic CMD_ACTUATE = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// configuration register indexes
	localparam logic CFG_MIN_DUTY = 1'b0;
	localparam logic CFG_MAX_DUTY = 1'b1;

	typedef struct packed {
		logic                      command;
		logic signed [POWER_W-1:0] power_value;
	} in_beat_t;

	typedef struct packed {
		logic              drive_valid;
		logic [DUTY_W-1:0] forward_duty;
		logic [DUTY_W-1:0] reverse_duty;
		logic [1:0]        status;
	} out_beat_t;

endpackage

>>> design/motor_power_queue_to_pwm_duty_top.sv
// ----------------------------------------------------------------------------
// motor_power_queue_to_pwm_duty_top: signed power queue feeding H-bridge duties
//
// Input channel (in_valid / in_stall / in_data): each beat either pushes a
// signed power value into a ring queue of QUEUE_DEPTH entries or pops the
// oldest one and turns it into a forward and a reverse duty, clamped to the
// min_duty / max_duty registers. Every input beat yields exactly one output
// beat (out_valid / out_stall / out_data) carrying the duties and a status.
// Pushing into a full queue or actuating an empty one leaves the queue as is
// and reports it in status.
// Path: an accepted beat is held in stage 1, then in the output register, and
// is taken from there. Throughput: one beat per cycle while out_stall is low;
// the queue bookkeeping and memory port are updated at the accepting edge, the
// stored value is read into stage 1 and clamped into the output register.
// Stall: the output register holds while out_stall is high; stage 1 then
// fills, and in_stall rises until the output beat is taken.
// Reset: queue empty, duty limits back to 4 and 49996, no beat in flight. The
// storage itself is not cleared; only written entries are read. The user must
// write configuration (cfg_we/cfg_index/cfg_data) only while idle; unenforced.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module motor_power_queue_to_pwm_duty_top #(
	parameter int QUEUE_DEPTH = mpqpwm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mpqpwm_pkg::in_beat_t            in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mpqpwm_pkg::out_beat_t           out_data,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [mpqpwm_pkg::DUTY_W-1:0]   cfg_data
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// configuration
	logic [mpqpwm_pkg::DUTY_W-1:0] min_duty_q;
	logic [mpqpwm_pkg::DUTY_W-1:0] max_duty_q;

	// queue state
	logic [mpqpwm_pkg::POWER_W-1:0] power_store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]               wr_ptr_q;
	logic [PTR_W-1:0]               rd_ptr_q;
	logic [CNT_W-1:0]               cnt_q;

	// stage 1
	logic                           valid_s1;
	logic                           pop_s1;
	logic [1:0]                     status_s1;
	logic [mpqpwm_pkg::POWER_W-1:0] raw_s1;

	// output register
	logic                  out_valid_q;
	mpqpwm_pkg::out_beat_t out_data_q;

	logic                           adv;
	logic                           accept;
	logic                           full;
	logic                           empty;
	logic                           push_ok;
	logic                           pop_ok;
	logic                           neg;
	logic [mpqpwm_pkg::POWER_W-1:0] mag;
	logic [mpqpwm_pkg::POWER_W-1:0] min_ext;
	logic [mpqpwm_pkg::POWER_W-1:0] max_ext;
	logic [mpqpwm_pkg::DUTY_W-1:0]  duty;
	mpqpwm_pkg::out_beat_t          res;

	assign adv      = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign accept   = in_valid && !in_stall;
	assign full     = (cnt_q == CNT_FULL);
	assign empty    = (cnt_q == '0);
	assign push_ok  = accept && (in_data.command == mpqpwm_pkg::CMD_PUSH) && !full;
	assign pop_ok   = accept && (in_data.command == mpqpwm_pkg::CMD_ACTUATE) && !empty;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_duty_q <= mpqpwm_pkg::MIN_DUTY_RST;
			max_duty_q <= mpqpwm_pkg::MAX_DUTY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mpqpwm_pkg::CFG_MIN_DUTY: min_duty_q <= cfg_data;
				mpqpwm_pkg::CFG_MAX_DUTY: max_duty_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// queue pointers and fill count move at the accepting edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (push_ok) begin
			wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			cnt_q    <= cnt_q + 1'b1;
		end else if (pop_ok) begin
			rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			cnt_q    <= cnt_q - 1'b1;
		end
	end

	// storage: one write, one registered read
	always_ff @(posedge clk) begin
		if (push_ok) begin
			power_store_q[wr_ptr_q] <= in_data.power_value;
		end
		if (pop_ok) begin
			raw_s1 <= power_store_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_s1 <= pop_ok;
			if (in_data.command == mpqpwm_pkg::CMD_PUSH) begin
				status_s1 <= full ? mpqpwm_pkg::ST_FULL : mpqpwm_pkg::ST_OK;
			end else begin
				status_s1 <= empty ? mpqpwm_pkg::ST_EMPTY : mpqpwm_pkg::ST_OK;
			end
		end
	end

	// sign-magnitude split and clamp; the most negative value negates to 2^31
	always_comb begin
		neg     = raw_s1[mpqpwm_pkg::POWER_W-1];
		mag     = neg ? ('0 - raw_s1) : raw_s1;
		min_ext = mpqpwm_pkg::POWER_W'(min_duty_q);
		max_ext = mpqpwm_pkg::POWER_W'(max_duty_q);
		if (mag != '0 && mag < min_ext) begin
			duty = min_duty_q;
		end else if (mag > max_ext) begin
			duty = max_duty_q;
		end else begin
			duty = mag[mpqpwm_pkg::DUTY_W-1:0];
		end
		res.drive_valid  = pop_s1;
		res.forward_duty = (pop_s1 && !neg) ? duty : '0;
		res.reverse_duty = (pop_s1 && neg) ? duty : '0;
		res.status       = status_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q <= res;
		end
	end

	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_FULL, "fill count beyond queue depth")
	`ASSERT_CLK(a_push_count, push_ok |=> cnt_q == $past(cnt_q) + 1'b1,
		"push did not grow count")
	`ASSERT_CLK(a_full_hold,
		accept && in_data.command == mpqpwm_pkg::CMD_PUSH && full
		|=> $stable(cnt_q) && $stable(wr_ptr_q),
		"push on full queue changed state")
	`ASSERT_CLK(a_drive_ok,
		out_valid_q && out_data_q.drive_valid
		|-> out_data_q.status == mpqpwm_pkg::ST_OK
		&& (out_data_q.forward_duty == '0 || out_data_q.reverse_duty == '0),
		"drive beat with bad status or both channels on")
	`ASSERT_CLK(a_empty_no_pop, accept && empty |-> !pop_ok, "pop from empty queue")

endmodule

>>> dv/motor_duty_checker.sv
// ----------------------------------------------------------------------------
// motor_duty_checker: scoreboard for the motor power queue to PWM duty block
// Watches the input, output and register ports, keeps its own copy of the
// power ring and duty limits, predicts one duty beat per accepted input beat
// and compares each accepted output beat field by field, in order.
// ----------------------------------------------------------------------------
module motor_duty_checker #(
	parameter int QUEUE_DEPTH = mpqpwm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  mpqpwm_pkg::in_beat_t          in_data,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  mpqpwm_pkg::out_beat_t         out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [mpqpwm_pkg::DUTY_W-1:0] cfg_data,
	output int                            mismatches,
	output int                            in_flight,
	output int                            n_driven,
	output int                            n_full,
	output int                            n_empty
);

	localparam int PRINT_CAP = 40;

	logic [mpqpwm_pkg::POWER_W-1:0] power_ring [QUEUE_DEPTH];
	int                             ring_wr;
	int                             ring_rd;
	int                             ring_count;
	logic [mpqpwm_pkg::DUTY_W-1:0]  lim_min;
	logic [mpqpwm_pkg::DUTY_W-1:0]  lim_max;
	mpqpwm_pkg::out_beat_t          pending_duties [$];
	mpqpwm_pkg::out_beat_t          want;

	initial begin
		mismatches = 0;
		in_flight  = 0;
		n_driven   = 0;
		n_full     = 0;
		n_empty    = 0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] duty mismatch: %s", $realtime, msg);
		else if (mismatches == PRINT_CAP + 1)
			$display("[%0t] further duty mismatches counted without detail", $realtime);
	endtask

	// Applies one command to the ring and returns the beat it must produce.
	function automatic mpqpwm_pkg::out_beat_t predict_duty(input mpqpwm_pkg::in_beat_t b);
		mpqpwm_pkg::out_beat_t          r;
		logic [mpqpwm_pkg::POWER_W-1:0] raw;
		logic [mpqpwm_pkg::POWER_W-1:0] mag;
		logic                           reversing;
		r = '0;
		r.status = mpqpwm_pkg::ST_OK;
		if (b.command == mpqpwm_pkg::CMD_PUSH) begin
			if (ring_count >= QUEUE_DEPTH) begin
				r.status = mpqpwm_pkg::ST_FULL;
			end else begin
				power_ring[ring_wr] = b.power_value;
				ring_wr = (ring_wr == QUEUE_DEPTH - 1) ? 0 : ring_wr + 1;
				ring_count++;
			end
		end else if (ring_count == 0) begin
			r.status = mpqpwm_pkg::ST_EMPTY;
		end else begin
			raw = power_ring[ring_rd];
			ring_rd = (ring_rd == QUEUE_DEPTH - 1) ? 0 : ring_rd + 1;
			ring_count--;
			reversing = raw[mpqpwm_pkg::POWER_W-1];
			// most negative value: 0 - raw leaves 2^31, which the clamp handles
			mag = reversing ? (32'd0 - raw) : raw;
			if (mag != 0 && mag < {16'd0, lim_min})
				mag = {16'd0, lim_min};
			else if (mag > {16'd0, lim_max})
				mag = {16'd0, lim_max};
			if (reversing)
				r.reverse_duty = mag[mpqpwm_pkg::DUTY_W-1:0];
			else
				r.forward_duty = mag[mpqpwm_pkg::DUTY_W-1:0];
			r.drive_valid = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_wr    = 0;
			ring_rd    = 0;
			ring_count = 0;
			lim_min    = mpqpwm_pkg::MIN_DUTY_RST;
			lim_max    = mpqpwm_pkg::MAX_DUTY_RST;
			pending_duties.delete();
			in_flight <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == mpqpwm_pkg::CFG_MIN_DUTY)
					lim_min = cfg_data;
				else if (cfg_index == mpqpwm_pkg::CFG_MAX_DUTY)
					lim_max = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (pending_duties.size() == 0) begin
					report_mismatch($sformatf("output beat %h with nothing expected", out_data));
				end else begin
					want = pending_duties.pop_front();
					if (out_data.drive_valid !== want.drive_valid)
						report_mismatch($sformatf("drive_valid got %b want %b",
							out_data.drive_valid, want.drive_valid));
					if (out_data.forward_duty !== want.forward_duty)
						report_mismatch($sformatf("forward_duty got %0d want %0d",
							out_data.forward_duty, want.forward_duty));
					if (out_data.reverse_duty !== want.reverse_duty)
						report_mismatch($sformatf("reverse_duty got %0d want %0d",
							out_data.reverse_duty, want.reverse_duty));
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							out_data.status, want.status));
					n_driven += want.drive_valid;
					if (want.status == mpqpwm_pkg::ST_FULL)
						n_full++;
					if (want.status == mpqpwm_pkg::ST_EMPTY)
						n_empty++;
				end
			end
			if (in_valid && !in_stall)
				pending_duties.push_back(predict_duty(in_data));
			in_flight <= pending_duties.size();
		end
	end

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for motor_power_queue_to_pwm_duty_top
// Drives push and actuate beats through several duty-limit settings, first a
// directed set of edge values, then bursts of pushes and pops with random
// power values and random idling on both sides; the checker scores results.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int N_PHASES    = 8;
	localparam int PHASE_BEATS = 160;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	mpqpwm_pkg::in_beat_t          in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	mpqpwm_pkg::out_beat_t         out_data;
	logic                          cfg_we    = 1'b0;
	logic                          cfg_index = 1'b0;
	logic [mpqpwm_pkg::DUTY_W-1:0] cfg_data  = '0;

	int                            mismatches;
	int                            in_flight;
	int                            n_driven;
	int                            n_full;
	int                            n_empty;
	int                            cycles    = 0;
	int                            idle_pct  = 37;
	int                            stall_pct = 37;
	int                            beats_sent = 0;
	logic [mpqpwm_pkg::DUTY_W-1:0] cur_min   = mpqpwm_pkg::MIN_DUTY_RST;
	logic [mpqpwm_pkg::DUTY_W-1:0] cur_max   = mpqpwm_pkg::MAX_DUTY_RST;

	motor_power_queue_to_pwm_duty_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	motor_duty_checker duty_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.in_flight  (in_flight),
		.n_driven   (n_driven),
		.n_full     (n_full),
		.n_empty    (n_empty)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still expected", cycles, in_flight);
			$display("tb: errors");
			$finish;
		end
	end

	task automatic send_beat(input logic cmd, input logic [mpqpwm_pkg::POWER_W-1:0] pv);
		mpqpwm_pkg::in_beat_t b;
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		b.command     = cmd;
		b.power_value = pv;
		in_valid <= 1'b1;
		in_data  <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	// hold off until every predicted beat has come out, then let the pipe settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limits(input logic [mpqpwm_pkg::DUTY_W-1:0] lo,
		input logic [mpqpwm_pkg::DUTY_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= mpqpwm_pkg::CFG_MIN_DUTY;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= mpqpwm_pkg::CFG_MAX_DUTY;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we  <= 1'b0;
		cur_min = lo;
		cur_max = hi;
	endtask

	// power values, many aimed at the clamp edges of the current limits
	function automatic logic [mpqpwm_pkg::POWER_W-1:0] pick_power();
		logic [mpqpwm_pkg::POWER_W-1:0] v;
		int                             lo;
		int                             hi;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 8);
			2: begin
				lo = (int'(cur_min) > 2) ? int'(cur_min) - 2 : 0;
				hi = int'(cur_min) + 2;
				v = $urandom_range(lo, hi);
			end
			3: begin
				lo = (int'(cur_max) > 2) ? int'(cur_max) - 2 : 0;
				hi = int'(cur_max) + 2;
				v = $urandom_range(lo, hi);
			end
			4: v = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: v = $urandom_range(0, 70000);
		endcase
		if ($urandom_range(0, 1))
			v = 32'd0 - v;
		return v;
	endfunction

	// bursts of pushes and pops so the ring runs full and empty; some noise
	task automatic run_random(input int count);
		int sent;
		int kind;
		int burst;
		sent = 0;
		while (sent < count) begin
			kind  = $urandom_range(0, 19);
			burst = $urandom_range(1, 20);
			for (int k = 0; k < burst && sent < count; k++) begin
				if (kind < 9)
					send_beat(mpqpwm_pkg::CMD_PUSH, pick_power());
				else if (kind < 18)
					send_beat(mpqpwm_pkg::CMD_ACTUATE, $urandom);
				else
					send_beat(1'($urandom_range(0, 1)), $urandom);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, fill with edge values, overflow, then drain part
		send_beat(mpqpwm_pkg::CMD_ACTUATE, 32'h0000_0000);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd0);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd1);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd3);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd4);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd49996);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd49997);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'h7fff_ffff);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'h8000_0000);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'hffff_ffff);
		send_beat(mpqpwm_pkg::CMD_PUSH, -32'sd3);
		send_beat(mpqpwm_pkg::CMD_PUSH, -32'sd4);
		send_beat(mpqpwm_pkg::CMD_PUSH, -32'sd49996);
		send_beat(mpqpwm_pkg::CMD_PUSH, -32'sd49997);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'd65535);
		send_beat(mpqpwm_pkg::CMD_PUSH, -32'sd65536);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'h0001_0000);
		send_beat(mpqpwm_pkg::CMD_PUSH, 32'h5555_aaaa);
		repeat (7) send_beat(mpqpwm_pkg::CMD_ACTUATE, $urandom);

		for (int p = 0; p < N_PHASES; p++) begin
			if (p != 0) begin
				wait_drained();
				case (p)
					1: set_limits(16'd0, 16'd65535);
					2: set_limits(16'd65535, 16'd0);
					3: set_limits(16'd0, 16'd0);
					4: set_limits(16'd300, 16'd100);
					5: set_limits(16'd65535, 16'd65535);
					6: set_limits(16'($urandom), 16'($urandom));
					default: set_limits(mpqpwm_pkg::MIN_DUTY_RST, mpqpwm_pkg::MAX_DUTY_RST);
				endcase
			end
			// one phase runs flat out on both sides
			idle_pct  = (p == 1) ? 0 : 37;
			stall_pct = (p == 1) ? 0 : 37;
			run_random((p == 0) ? PHASE_BEATS - 25 : PHASE_BEATS);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("summary: %0d beats over %0d duty-limit settings", beats_sent, N_PHASES);
		$display("summary: %0d drove the bridge, %0d pushes on full, %0d pops on empty",
			n_driven, n_full, n_empty);
		if (mismatches == 0 && in_flight == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/mpqpwm_pkg.sv
design/motor_power_queue_to_pwm_duty_top.sv
dv/motor_duty_checker.sv
dv/tb.sv
